// ----- src/convex_hull_graham_scan_unit_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on nothing; each file that asserts includes it.
`ifndef CONVEX_HULL_GRAHAM_SCAN_UNIT_MACROS_SVH
`define CONVEX_HULL_GRAHAM_SCAN_UNIT_MACROS_SVH

// Clocked property, muted while reset is high.
`define CGHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define CGHS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/cghs_pkg.sv -----
// Shared constants and types for the convex hull unit.
// Used by every module of the block; depends on nothing.
package cghs_pkg;

  localparam int MAX_POINTS = 32;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int DIST_W     = DIFF_W + 1;
  localparam int BEAT_W     = 2 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic        [DIST_W-1:0]     dist_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    coord_t           piv_x;
    coord_t           piv_y;
    logic             ovf;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    coord_t           x;
    coord_t           y;
  } pt_wr_t;

endpackage

// ----- src/cghs_front.sv -----
// Front end: accepts point beats, stores them and tracks the pivot.
// Depends on cghs_pkg; feeds cghs_job_queue and the point memory in cghs_back.
module cghs_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // x_coord [15:0], y_coord [31:16]
  input  logic                  s_tlast,   // last_point
  input  logic                  q_full,
  input  logic                  done,
  output logic                  job_push,
  output cghs_pkg::job_t        job,
  output cghs_pkg::pt_wr_t      wr
);
  import cghs_pkg::*;

  logic [CNT_W-1:0] count, cnt_inc;
  logic             ovf, busy, accept, room, better;
  coord_t           piv_x, piv_y, in_x, in_y, pvx_n, pvy_n;

  always_comb begin
    in_x     = s_tdata[COORD_BITS-1:0];
    in_y     = s_tdata[BEAT_W-1:COORD_BITS];
    s_tready = !busy && !q_full;
    accept   = s_tvalid && s_tready;
    room     = count < CNT_W'(MAX_POINTS);
    better   = (count == '0) || (in_y < piv_y) || ((in_y == piv_y) && (in_x < piv_x));
    cnt_inc  = room ? count + CNT_W'(1) : count;
    pvx_n    = (room && better) ? in_x : piv_x;
    pvy_n    = (room && better) ? in_y : piv_y;
    wr.en    = accept && room;
    wr.addr  = count[IDX_W-1:0];
    wr.x     = in_x;
    wr.y     = in_y;
    job_push = accept && s_tlast;
    job.count = cnt_inc;
    job.piv_x = pvx_n;
    job.piv_y = pvy_n;
    job.ovf   = ovf || !room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      busy  <= 1'b0;
    end else begin
      if (done) begin
        busy <= 1'b0;
      end
      if (accept) begin
        if (s_tlast) begin
          count <= '0;
          ovf   <= 1'b0;
          busy  <= 1'b1;
        end else begin
          count <= cnt_inc;
          ovf   <= ovf || !room;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      piv_x <= pvx_n;
      piv_y <= pvy_n;
    end
  end

endmodule

// ----- src/cghs_job_queue.sv -----
// Two-entry queue of closed point sets between front and back.
// Depends on cghs_pkg.
module cghs_job_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cghs_pkg::job_t din,
  input  logic           pop,
  output cghs_pkg::job_t dout,
  output logic           empty,
  output logic           full
);
  import cghs_pkg::*;

  job_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  always_comb begin
    dout  = entry[rd_ptr];
    empty = (fill == 2'd0);
    full  = (fill == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= din;
    end
  end

endmodule

// ----- src/cghs_back.sv -----
// Back end: point memory, hull walk sequencer and output register.
// Depends on cghs_pkg; takes jobs from cghs_job_queue.
module cghs_back (
  input  logic             clk,
  input  logic             rst,
  input  cghs_pkg::pt_wr_t wr,
  input  logic             q_empty,
  input  cghs_pkg::job_t   q_head,
  output logic             q_pop,
  output logic             done,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // hull_x [15:0], hull_y [31:16]
  output logic             m_tlast,   // last_vertex
  output logic             m_tuser    // overflowed
);
  import cghs_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_CMP, S_EMIT} state_t;

  state_t           state;
  coord_t           mem_x [MAX_POINTS];
  coord_t           mem_y [MAX_POINTS];
  coord_t           rd_x, rd_y, cur_x, cur_y, q_x, q_y, piv_x, piv_y, e_x, e_y;
  logic [CNT_W-1:0] n_pts;
  logic [IDX_W-1:0] idx;
  logic             ovf, have, p_same, take, scan_end, e_last, out_free;
  prod_t            m1, m2;
  cross_t           cr;
  dist_t            q_dist, p_dist, dist_c;
  diff_t            dxq, dyq, dxp, dyp;
  logic [DIFF_W-1:0] adx, ady;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_x[wr.addr] <= wr.x;
      mem_y[wr.addr] <= wr.y;
    end
    rd_x <= mem_x[idx];
    rd_y <= mem_y[idx];
  end

  always_comb begin
    dxq      = diff_t'(q_x) - diff_t'(cur_x);
    dyq      = diff_t'(q_y) - diff_t'(cur_y);
    dxp      = diff_t'(rd_x) - diff_t'(cur_x);
    dyp      = diff_t'(rd_y) - diff_t'(cur_y);
    adx      = dxp[DIFF_W-1] ? DIFF_W'(-dxp) : DIFF_W'(dxp);
    ady      = dyp[DIFF_W-1] ? DIFF_W'(-dyp) : DIFF_W'(dyp);
    dist_c   = DIST_W'(adx) + DIST_W'(ady);
    cr       = cross_t'(m1) - cross_t'(m2);
    take     = !p_same && (!have || (cr > 0) || ((cr == 0) && (p_dist > q_dist)));
    scan_end = (CNT_W'(idx) + CNT_W'(1)) == n_pts;
    e_x      = have ? q_x : piv_x;
    e_y      = have ? q_y : piv_y;
    e_last   = !have || ((q_x == piv_x) && (q_y == piv_y));
    out_free = !m_tvalid || m_tready;
    q_pop    = (state == S_IDLE) && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      done     <= 1'b0;
      idx      <= '0;
      have     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            n_pts <= q_head.count;
            piv_x <= q_head.piv_x;
            piv_y <= q_head.piv_y;
            cur_x <= q_head.piv_x;
            cur_y <= q_head.piv_y;
            ovf   <= q_head.ovf;
            idx   <= '0;
            have  <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_MUL;
        end
        S_MUL: begin
          m1     <= prod_t'(dxq) * prod_t'(dyp);
          m2     <= prod_t'(dyq) * prod_t'(dxp);
          p_dist <= dist_c;
          p_same <= (rd_x == cur_x) && (rd_y == cur_y);
          state  <= S_CMP;
        end
        S_CMP: begin
          if (take) begin
            q_x    <= rd_x;
            q_y    <= rd_y;
            q_dist <= p_dist;
            have   <= 1'b1;
          end
          if (scan_end) begin
            state <= S_EMIT;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_READ;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {e_y, e_x};
            m_tlast  <= e_last;
            m_tuser  <= ovf;
            if (e_last) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              cur_x <= q_x;
              cur_y <= q_y;
              idx   <= '0;
              have  <= 1'b0;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/convex_hull_graham_scan_unit.sv -----
// Top level of the convex hull unit: front end, job queue and back end.
// Depends on cghs_pkg, cghs_front, cghs_job_queue and cghs_back.
//
// Input stream: one point per beat, x in s_tdata[15:0], y in s_tdata[31:16],
// s_tlast on the final point of a set. Up to 32 points are kept; later ones
// are dropped and the set's results carry m_tuser high.
// Output stream: hull vertices clockwise, starting next to the pivot (lowest
// y, then lowest x) and ending with the pivot, which carries m_tlast.
// Points load at one beat per cycle while s_tready is high. Once a set
// closes, the back end walks the hull one vertex at a time, sweeping every
// stored point through a single cross-product unit by read, multiply and
// compare, one point at a time and not pipelined.
// s_tready stays low from the last point of a set until the pivot beat is
// loaded into the output register.
// A stalled receiver holds the output register and pauses the walk; no beat
// is lost. Synchronous reset empties the point set, the queue and the output.
module convex_hull_graham_scan_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // x_coord [15:0], y_coord [31:16]
  input  logic        s_tlast,   // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // hull_x [15:0], hull_y [31:16]
  output logic        m_tlast,   // last_vertex
  output logic        m_tuser    // overflowed
);
  import cghs_pkg::*;

  job_t   job, q_head;
  pt_wr_t wr;
  logic   job_push, q_full, q_empty, q_pop, done;

  cghs_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .q_full, .done, .job_push, .job, .wr
  );

  cghs_job_queue u_queue (
    .clk, .rst, .push(job_push), .din(job), .pop(q_pop),
    .dout(q_head), .empty(q_empty), .full(q_full)
  );

  cghs_back u_back (
    .clk, .rst, .wr, .q_empty, .q_head, .q_pop, .done,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
  );

endmodule

// ----- src/cghs_checker.sv -----
// Port-level checks for the convex hull unit, bound to the top level.
// Depends on convex_hull_graham_scan_unit_macros.svh.
`include "convex_hull_graham_scan_unit_macros.svh"

module cghs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  `CGHS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "beat dropped")
  `CGHS_ASSERT_RST(a_rst_out, rst |=> !m_tvalid, "output valid after reset")
  `CGHS_ASSERT(a_set_closed, s_tvalid && s_tready && s_tlast |=> !s_tready, "input open after set")
  `CGHS_ASSERT(a_out_known, m_tvalid |-> !$isunknown({m_tdata, m_tlast, m_tuser}), "unknown output beat")
  `CGHS_ASSERT(a_in_known, s_tvalid |-> !$isunknown({s_tdata, s_tlast}), "unknown input beat")

endmodule

bind convex_hull_graham_scan_unit cghs_checker u_checker (.*);
